@@ sv/ipav_pkg.sv @@
`timescale 1ns / 1ps

package ipav_pkg;

  // Per-string scan state, one field per counter or flag
  typedef struct packed {
    logic [2:0] dot_total;        // saturates at 4
    logic [3:0] colon_total;      // saturates at 8
    logic       v4_still_ok;
    logic [9:0] v4_group_value;   // first three digits of the group
    logic [2:0] v4_group_digits;  // saturates at 4
    logic       v4_leading_zero;
    logic       v6_still_ok;
    logic [2:0] v6_group_digits;  // saturates at 5
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    dot_total:       3'd0,
    colon_total:     4'd0,
    v4_still_ok:     1'b1,
    v4_group_value:  10'd0,
    v4_group_digits: 3'd0,
    v4_leading_zero: 1'b0,
    v6_still_ok:     1'b1,
    v6_group_digits: 3'd0
  };

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_NEITHER = 2'd0;
  localparam verdict_t VERDICT_IPV4    = 2'd1;
  localparam verdict_t VERDICT_IPV6    = 2'd2;

  localparam logic [7:0] CHAR_DOT     = 8'd46;
  localparam logic [7:0] CHAR_COLON   = 8'd58;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_F = 8'd70;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_F = 8'd102;

  localparam logic [9:0] V4_GROUP_MAX   = 10'd255;
  localparam logic [2:0] V4_DIGITS_MAX  = 3'd3;
  localparam logic [2:0] V4_DIGITS_SAT  = 3'd4;
  localparam logic [2:0] V6_DIGITS_MAX  = 3'd4;
  localparam logic [2:0] V6_DIGITS_SAT  = 3'd5;
  localparam logic [2:0] DOT_SAT        = 3'd4;
  localparam logic [3:0] COLON_SAT      = 4'd8;
  localparam logic [2:0] V4_DOTS        = 3'd3;
  localparam logic [3:0] V6_COLONS      = 4'd7;

endpackage

@@ sv/ipav_step.sv @@
`timescale 1ns / 1ps

module ipav_step (
  input  ipav_pkg::scan_state_t cur_state,
  input  logic [7:0]            char_code,
  input  logic                  is_last,
  output ipav_pkg::scan_state_t nxt_state,
  output ipav_pkg::verdict_t    verdict
);
  import ipav_pkg::*;

  logic        is_dec;
  logic        is_hex;
  logic [3:0]  dec_digit;
  logic [9:0]  value_x10;
  scan_state_t mid;
  scan_state_t fin;

  assign is_dec    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_hex    = is_dec ||
                     ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F)) ||
                     ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F));
  assign dec_digit = char_code[3:0];
  // value stays below 100 whenever it is scaled, so 10 bits hold the product
  assign value_x10 = {cur_state.v4_group_value[6:0], 3'b000} +
                     {cur_state.v4_group_value[8:0], 1'b0};

  // Apply one character to both checks
  always_comb begin
    mid = cur_state;

    if (char_code == CHAR_DOT) begin
      if (cur_state.dot_total < DOT_SAT) mid.dot_total = cur_state.dot_total + 3'd1;
      if ((cur_state.v4_group_digits == 3'd0) ||
          (cur_state.v4_group_digits > V4_DIGITS_MAX) ||
          (cur_state.v4_group_value > V4_GROUP_MAX)) begin
        mid.v4_still_ok = 1'b0;
      end
      mid.v4_group_value  = 10'd0;
      mid.v4_group_digits = 3'd0;
      mid.v4_leading_zero = 1'b0;
    end else if (is_dec) begin
      if ((cur_state.v4_group_digits != 3'd0) && cur_state.v4_leading_zero) begin
        mid.v4_still_ok = 1'b0;
      end
      if ((cur_state.v4_group_digits == 3'd0) && (char_code == CHAR_ZERO)) begin
        mid.v4_leading_zero = 1'b1;
      end
      if (cur_state.v4_group_digits < V4_DIGITS_MAX) begin
        mid.v4_group_value = value_x10 + {6'd0, dec_digit};
      end
      if (cur_state.v4_group_digits < V4_DIGITS_SAT) begin
        mid.v4_group_digits = cur_state.v4_group_digits + 3'd1;
      end
      if (cur_state.v4_group_digits >= V4_DIGITS_MAX) mid.v4_still_ok = 1'b0;
    end else begin
      mid.v4_still_ok = 1'b0;
    end

    if (char_code == CHAR_COLON) begin
      if (cur_state.colon_total < COLON_SAT) begin
        mid.colon_total = cur_state.colon_total + 4'd1;
      end
      if ((cur_state.v6_group_digits == 3'd0) ||
          (cur_state.v6_group_digits > V6_DIGITS_MAX)) begin
        mid.v6_still_ok = 1'b0;
      end
      mid.v6_group_digits = 3'd0;
    end else if (is_hex) begin
      if (cur_state.v6_group_digits < V6_DIGITS_SAT) begin
        mid.v6_group_digits = cur_state.v6_group_digits + 3'd1;
      end
    end else begin
      mid.v6_still_ok = 1'b0;
    end
  end

  // Close the open groups at end of string and decide
  always_comb begin
    fin = mid;
    if ((mid.v4_group_digits == 3'd0) || (mid.v4_group_digits > V4_DIGITS_MAX) ||
        (mid.v4_group_value > V4_GROUP_MAX)) begin
      fin.v4_still_ok = 1'b0;
    end
    if ((mid.v6_group_digits == 3'd0) || (mid.v6_group_digits > V6_DIGITS_MAX)) begin
      fin.v6_still_ok = 1'b0;
    end

    priority if (fin.dot_total == V4_DOTS) begin
      verdict = fin.v4_still_ok ? VERDICT_IPV4 : VERDICT_NEITHER;
    end else if (fin.colon_total == V6_COLONS) begin
      verdict = fin.v6_still_ok ? VERDICT_IPV6 : VERDICT_NEITHER;
    end else begin
      verdict = VERDICT_NEITHER;
    end
  end

  assign nxt_state = is_last ? SCAN_RESET : mid;

endmodule

@@ sv/ip_address_text_validator.sv @@
`timescale 1ns / 1ps
// A string's verdict reaches out_tvalid through the input register, then the result register.
// Throughput: one character word per cycle, but a last character waits while the result
//   register is full and stalled; the per-character state update is one combinational
//   step between the input register and the scan state / result registers.
// Reset (rst_n low, synchronous): input and output stages empty, scan state back to the
//   start of a string.

module ip_address_text_validator (
  input  logic       clk,
  input  logic       rst_n,
  // input character stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // is_last
  // verdict stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] verdict, [7:2] zero
);
  import ipav_pkg::*;

  // Input register: one character word waiting to be scanned
  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        s1_adv;

  // Scan state across the characters of one string
  scan_state_t state_r;
  scan_state_t state_nxt;
  verdict_t    step_verdict;

  // Result register
  logic        out_valid_r;
  verdict_t    out_verdict_r;

  // Advance the held character unless it would produce a verdict into a full,
  // stalled result register. Only last characters write the result register.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload: capture on every acceptance, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  ipav_step u_step (
    .cur_state (state_r),
    .char_code (s1_char_r),
    .is_last   (s1_last_r),
    .nxt_state (state_nxt),
    .verdict   (step_verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCAN_RESET;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Hold the verdict until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_verdict_r <= step_verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_verdict_r};

  // A finished string leaves the scan state at its start value
  a_state_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> state_r == SCAN_RESET)
    else $error("scan state not restarted after last character");

  // A verdict is always one of the three defined codes
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r == VERDICT_NEITHER || out_verdict_r == VERDICT_IPV4 ||
                     out_verdict_r == VERDICT_IPV6))
    else $error("undefined verdict code");

  // A held character that cannot advance stays in place
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_char_r) && $stable(s1_last_r))
    else $error("input register lost a stalled character");

  // The scan state only moves when a character is consumed
  a_state_still: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(state_r))
    else $error("scan state changed without a character");

endmodule
